// File: hw/rtl/bbpe_pkg.sv
// ----------------------------------------------------------------------------
// bbpe_pkg
// Shared types, widths and codes for the binary boundary pixel extractor.
// ----------------------------------------------------------------------------
package bbpe_pkg;

    // payload widths
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 11;
    localparam int INDEX_W   = 16;
    localparam int SIZE_W    = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // size compare width, covers the largest line/frame parameter (8192)
    localparam int CMP_W     = 14;
    localparam int MIN_SIZE  = 3;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

    localparam logic [SIZE_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [SIZE_W-1:0]  HEIGHT_RST = 12'd480;
    localparam logic [INDEX_W-1:0] LIMIT_RST  = 16'd1000;

    // pixel classes
    localparam logic [1:0] CLS_NONE  = 2'b00;
    localparam logic [1:0] CLS_WHITE = 2'b01;
    localparam logic [1:0] CLS_BLACK = 2'b10;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    // 3x3 window, 6 bits per column; black bits of the 8 neighbors
    localparam int WIN_W = 18;
    localparam logic [WIN_W-1:0] NBR_BLACK_MASK = 18'h2A8AA;

    // candidate queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one entry between the front and the back
    typedef struct packed {
        logic               boundary;   // interior white pixel with a black neighbor
        logic               clr_before; // frame start: clear point count first
        logic               clr_after;  // last pixel of frame: clear point count after
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_cand;

    function automatic logic [1:0] classify(input logic [PIX_W-1:0] pix);
        logic [1:0] cls;
        cls = CLS_NONE;
        if (pix == PIX_WHITE) begin
            cls = CLS_WHITE;
        end else if (pix == PIX_BLACK) begin
            cls = CLS_BLACK;
        end
        return cls;
    endfunction

endpackage

// File: hw/rtl/bbpe_pix_if.sv
// ----------------------------------------------------------------------------
// bbpe_pix_if
// Pixel stream channel: valid/ready with pixel value and frame start mark.
// ----------------------------------------------------------------------------
interface bbpe_pix_if;
    logic                       valid;
    logic                       ready;
    logic [bbpe_pkg::PIX_W-1:0] pixel_value;
    logic                       frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

// File: hw/rtl/bbpe_pt_if.sv
// ----------------------------------------------------------------------------
// bbpe_pt_if
// Boundary point channel: valid/ready with column, row and running index.
// ----------------------------------------------------------------------------
interface bbpe_pt_if;
    logic                         valid;
    logic                         ready;
    logic [bbpe_pkg::COORD_W-1:0] point_col;
    logic [bbpe_pkg::COORD_W-1:0] point_row;
    logic [bbpe_pkg::INDEX_W-1:0] point_index;

    modport source (output valid, output point_col, output point_row,
                    output point_index, input ready);
    modport sink   (input valid, input point_col, input point_row,
                    input point_index, output ready);
endinterface

// File: hw/rtl/bbpe_front.sv
// ----------------------------------------------------------------------------
// bbpe_front
// Pixel intake: position counters, classing, line store, 3x3 window and
// boundary test. Pushes candidates into the queue.
// ----------------------------------------------------------------------------
module bbpe_front #(
    parameter int MAX_WIDTH  = bbpe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbpe_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bbpe_pix_if.sink                      i_pix,
    input  logic [bbpe_pkg::CMP_W-1:0]    i_width,
    input  logic [bbpe_pkg::CMP_W-1:0]    i_height,
    input  logic [bbpe_pkg::QCNT_W-1:0]   i_q_count,
    output logic                          o_push,
    output bbpe_pkg::t_cand               o_cand
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // line store entry: [1:0] row two above, [3:2] row one above
    logic [3:0] r_mem [MAX_WIDTH];
    logic [3:0] r_rd_data;
    logic       r_fwd;
    logic [3:0] r_fwd_data;

    logic [CW-1:0] r_col, n_col, col_cur, col_m1;
    logic [RW-1:0] r_row, n_row, row_cur, row_m1;

    // stage 1 (line store read in flight)
    logic                          r_s1_valid;
    logic [1:0]                    r_s1_cls;
    logic [CW-1:0]                 r_s1_col;
    logic                          r_s1_interior;
    logic                          r_s1_fs;
    logic                          r_s1_last;
    logic [bbpe_pkg::COORD_W-1:0]  r_s1_pcol;
    logic [bbpe_pkg::COORD_W-1:0]  r_s1_prow;

    logic [bbpe_pkg::WIN_W-1:0] r_win, win_base, win_n;
    logic [3:0] ent;
    logic [1:0] up, mid, centre;
    logic       acc, col_last, row_last, interior, boundary;
    logic [1:0] cls;

    // credit check: queue entries plus the one in flight
    assign i_pix.ready = (int'(i_q_count) + int'(r_s1_valid)) < bbpe_pkg::QUEUE_DEPTH;
    assign acc = i_pix.valid && i_pix.ready;

    always_comb begin
        col_cur  = i_pix.frame_start ? '0 : r_col;
        row_cur  = i_pix.frame_start ? '0 : r_row;
        col_last = (bbpe_pkg::CMP_W'(col_cur) + bbpe_pkg::CMP_W'(1)) >= i_width;
        row_last = (bbpe_pkg::CMP_W'(row_cur) + bbpe_pkg::CMP_W'(1)) >= i_height;
        interior = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
        col_m1   = col_cur - CW'(1);
        row_m1   = row_cur - RW'(1);
        cls      = bbpe_pkg::classify(i_pix.pixel_value);
        n_col    = col_cur + CW'(1);
        n_row    = row_cur;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : row_cur + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_cls      <= cls;
            r_s1_col      <= col_cur;
            r_s1_interior <= interior;
            r_s1_fs       <= i_pix.frame_start;
            r_s1_last     <= col_last && row_last;
            r_s1_pcol     <= bbpe_pkg::COORD_W'(col_m1);
            r_s1_prow     <= bbpe_pkg::COORD_W'(row_m1);
        end
    end

    // stage 2: window shift and boundary test
    always_comb begin
        ent      = r_fwd ? r_fwd_data : r_rd_data;
        up       = ent[1:0];
        mid      = ent[3:2];
        win_base = r_s1_fs ? '0 : r_win;
        win_n    = {r_s1_cls, mid, up, win_base[bbpe_pkg::WIN_W-1:6]};
        centre   = win_n[9:8];
        boundary = r_s1_interior && (centre == bbpe_pkg::CLS_WHITE)
                   && (|(win_n & bbpe_pkg::NBR_BLACK_MASK));
    end

    // line store; a write and a read at the same column forward the new entry
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= {r_s1_cls, mid};
        end
        r_rd_data  <= r_mem[col_cur];
        r_fwd      <= r_s1_valid && (r_s1_col == col_cur);
        r_fwd_data <= {r_s1_cls, mid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= win_n;
        end
    end

    assign o_push            = r_s1_valid && (boundary || r_s1_fs || r_s1_last);
    assign o_cand.boundary   = boundary;
    assign o_cand.clr_before = r_s1_fs;
    assign o_cand.clr_after  = r_s1_last;
    assign o_cand.col        = r_s1_pcol;
    assign o_cand.row        = r_s1_prow;

endmodule

// File: hw/rtl/bbpe_queue.sv
// ----------------------------------------------------------------------------
// bbpe_queue
// Short candidate FIFO between the front and the back.
// ----------------------------------------------------------------------------
module bbpe_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  bbpe_pkg::t_cand              i_cand,
    input  logic                         i_pop,
    output logic                         o_valid,
    output bbpe_pkg::t_cand              o_cand,
    output logic [bbpe_pkg::QCNT_W-1:0]  o_count
);

    bbpe_pkg::t_cand                 r_ent [bbpe_pkg::QUEUE_DEPTH];
    logic [bbpe_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [bbpe_pkg::QCNT_W-1:0]     r_count;
    logic                            do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_cand  = r_ent[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bbpe_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + bbpe_pkg::QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + bbpe_pkg::QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - bbpe_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_cand;
        end
    end

endmodule

// File: hw/rtl/bbpe_back.sv
// ----------------------------------------------------------------------------
// bbpe_back
// Point limit, running index and output register.
// ----------------------------------------------------------------------------
module bbpe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  bbpe_pkg::t_cand               i_cand,
    input  logic [bbpe_pkg::INDEX_W-1:0]  i_limit,
    output logic                          o_pop,
    bbpe_pt_if.source                     o_pt
);

    logic [bbpe_pkg::INDEX_W-1:0] r_sent, sent_eff;
    logic                         r_out_valid;
    logic [bbpe_pkg::COORD_W-1:0] r_out_col, r_out_row;
    logic [bbpe_pkg::INDEX_W-1:0] r_out_idx;
    logic                         emit, slot_free;

    assign sent_eff  = i_cand.clr_before ? '0 : r_sent;
    assign emit      = i_cand.boundary && (sent_eff < i_limit);
    assign slot_free = !r_out_valid || o_pt.ready;
    assign o_pop     = i_valid && (!emit || slot_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sent <= i_cand.clr_after ? '0 : sent_eff + bbpe_pkg::INDEX_W'(emit);
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_col <= i_cand.col;
            r_out_row <= i_cand.row;
            r_out_idx <= sent_eff;
        end
    end

    assign o_pt.valid       = r_out_valid;
    assign o_pt.point_col   = r_out_col;
    assign o_pt.point_row   = r_out_row;
    assign o_pt.point_index = r_out_idx;

endmodule

// File: hw/rtl/binary_boundary_pixel_extract_unit.sv
// Path: a boundary point passes the stage-1 registers, the candidate queue and the output register to o_pt.
// Throughput: one pixel per cycle sustained; the front pipeline runs on credits
//   against a four-entry candidate queue, so output stalls back up to i_pix.ready.
// Reset (i_rst_n low, synchronous): counters, window, queue, point count and output
//   valid clear; size/limit registers return to 640/480/1000. Line stores are not cleared.
// ----------------------------------------------------------------------------
// binary_boundary_pixel_extract_unit
// Streams a binary raster image and reports interior white pixels that touch
// a black 8-neighbor, with column, row and running index, up to a limit.
// ----------------------------------------------------------------------------
module binary_boundary_pixel_extract_unit #(
    parameter int MAX_WIDTH  = bbpe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbpe_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bbpe_pix_if.sink                        i_pix_if,
    bbpe_pt_if.source                       o_pt_if,
    input  logic                            i_cfg_we,
    input  logic [bbpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbpe_pkg::CFG_W-1:0]      i_cfg_data
);

    // configuration registers
    logic [bbpe_pkg::SIZE_W-1:0]  r_width, r_height;
    logic [bbpe_pkg::INDEX_W-1:0] r_limit;

    // clamped sizes
    logic [bbpe_pkg::CMP_W-1:0]   w_ext, h_ext, width_c, height_c;

    // front -> queue -> back
    logic                         push, pop, q_valid;
    bbpe_pkg::t_cand              cand_in, cand_out;
    logic [bbpe_pkg::QCNT_W-1:0]  q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bbpe_pkg::WIDTH_RST;
            r_height <= bbpe_pkg::HEIGHT_RST;
            r_limit  <= bbpe_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bbpe_pkg::REG_WIDTH:  r_width  <= i_cfg_data[bbpe_pkg::SIZE_W-1:0];
                bbpe_pkg::REG_HEIGHT: r_height <= i_cfg_data[bbpe_pkg::SIZE_W-1:0];
                bbpe_pkg::REG_LIMIT:  r_limit  <= i_cfg_data[bbpe_pkg::INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamp to MIN_SIZE..MAX_*; combinational so a write counts at once
    always_comb begin
        w_ext = bbpe_pkg::CMP_W'(r_width);
        h_ext = bbpe_pkg::CMP_W'(r_height);
        if (w_ext < bbpe_pkg::CMP_W'(bbpe_pkg::MIN_SIZE)) begin
            width_c = bbpe_pkg::CMP_W'(bbpe_pkg::MIN_SIZE);
        end else if (w_ext > bbpe_pkg::CMP_W'(MAX_WIDTH)) begin
            width_c = bbpe_pkg::CMP_W'(MAX_WIDTH);
        end else begin
            width_c = w_ext;
        end
        if (h_ext < bbpe_pkg::CMP_W'(bbpe_pkg::MIN_SIZE)) begin
            height_c = bbpe_pkg::CMP_W'(bbpe_pkg::MIN_SIZE);
        end else if (h_ext > bbpe_pkg::CMP_W'(MAX_HEIGHT)) begin
            height_c = bbpe_pkg::CMP_W'(MAX_HEIGHT);
        end else begin
            height_c = h_ext;
        end
    end

    // front: counters, line store, window, boundary test
    bbpe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix_if),
        .i_width   (width_c),
        .i_height  (height_c),
        .i_q_count (q_count),
        .o_push    (push),
        .o_cand    (cand_in)
    );

    // candidates plus frame-clear markers, in order
    bbpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cand  (cand_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cand  (cand_out),
        .o_count (q_count)
    );

    // back: limit check, running index, output register
    bbpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cand  (cand_out),
        .i_limit (r_limit),
        .o_pop   (pop),
        .o_pt    (o_pt_if)
    );

endmodule

// File: dv/bbpe_point_checker.sv
// ----------------------------------------------------------------------------
// bbpe_point_checker
// Watches the pixel, point and register channels of the boundary pixel
// extractor, predicts every boundary point and compares it field by field.
// ----------------------------------------------------------------------------
module bbpe_point_checker #(
    parameter int MAX_WIDTH  = bbpe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbpe_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bbpe_pix_if                            i_pix,
    bbpe_pt_if                             i_pt,
    input  logic                           i_cfg_we,
    input  logic [bbpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bbpe_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_points
);
    import bbpe_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [INDEX_W-1:0] index;
    } t_point;

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [INDEX_W-1:0] limit_reg;

    // pixel classes of the row two above and the row just above
    logic [1:0]         two_up_cls [MAX_WIDTH];
    logic [1:0]         one_up_cls [MAX_WIDTH];
    logic [WIN_W-1:0]   window;
    int unsigned        col_pos;
    int unsigned        row_pos;
    int unsigned        sent_count;

    t_point             expected_points [$];
    int                 fail_count  = 0;
    int                 point_count = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
        if (v < MIN_SIZE) begin
            return MIN_SIZE;
        end
        if (v > top) begin
            return top;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_REPORTS) begin
            $display("[%0t] point check: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic predict_pixel(input logic [PIX_W-1:0] pv, input logic fs);
        int unsigned w;
        int unsigned h;
        logic [1:0]  cls;
        logic [1:0]  up;
        logic [1:0]  mid;
        t_point      pt;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (fs) begin
            col_pos    = 0;
            row_pos    = 0;
            sent_count = 0;
            window     = '0;
        end
        if (col_pos >= MAX_WIDTH) begin
            col_pos = 0;
        end
        if (pv == PIX_WHITE) begin
            cls = CLS_WHITE;
        end else if (pv == PIX_BLACK) begin
            cls = CLS_BLACK;
        end else begin
            cls = CLS_NONE;
        end
        up  = two_up_cls[col_pos];
        mid = one_up_cls[col_pos];
        two_up_cls[col_pos] = mid;
        one_up_cls[col_pos] = cls;
        // newest column enters at the top, oldest drops out at the bottom
        window = {cls, mid, up, window[WIN_W-1:6]};
        if (row_pos >= 2 && col_pos >= 2 && window[9:8] == CLS_WHITE &&
            (window & NBR_BLACK_MASK) != '0 && sent_count < limit_reg) begin
            pt.col   = COORD_W'(col_pos - 1);
            pt.row   = COORD_W'(row_pos - 1);
            pt.index = INDEX_W'(sent_count);
            expected_points.push_back(pt);
            sent_count++;
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                row_pos    = 0;
                sent_count = 0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
    endtask

    task automatic check_point(input t_point got);
        t_point want;
        if (expected_points.size() == 0) begin
            report_mismatch($sformatf("unexpected point col %0d row %0d index %0d",
                                      got.col, got.row, got.index));
            return;
        end
        want = expected_points.pop_front();
        if (got.col !== want.col) begin
            report_mismatch($sformatf("col expected %0d got %0d (index %0d)",
                                      want.col, got.col, want.index));
        end
        if (got.row !== want.row) begin
            report_mismatch($sformatf("row expected %0d got %0d (index %0d)",
                                      want.row, got.row, want.index));
        end
        if (got.index !== want.index) begin
            report_mismatch($sformatf("index expected %0d got %0d",
                                      want.index, got.index));
        end
        point_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            limit_reg  = LIMIT_RST;
            for (int k = 0; k < MAX_WIDTH; k++) begin
                two_up_cls[k] = CLS_NONE;
                one_up_cls[k] = CLS_NONE;
            end
            window     = '0;
            col_pos    = 0;
            row_pos    = 0;
            sent_count = 0;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH: begin
                        width_reg = i_cfg_data[SIZE_W-1:0];
                    end
                    REG_HEIGHT: begin
                        height_reg = i_cfg_data[SIZE_W-1:0];
                    end
                    REG_LIMIT: begin
                        limit_reg = i_cfg_data[INDEX_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                predict_pixel(i_pix.pixel_value, i_pix.frame_start);
            end
            if (i_pt.valid && i_pt.ready) begin
                check_point({i_pt.point_col, i_pt.point_row, i_pt.point_index});
            end
        end
        o_pending    <= expected_points.size();
        o_fail_count <= fail_count;
        o_points     <= point_count;
    end

endmodule

// File: dv/binary_boundary_pixel_extract_unit_tb.sv
// ----------------------------------------------------------------------------
// binary_boundary_pixel_extract_unit_tb
// Streams binary raster frames into the extractor under random idling on both
// channels and across many size and limit settings; a checker beside the
// block predicts each boundary point and compares it.
// ----------------------------------------------------------------------------
module binary_boundary_pixel_extract_unit_tb;
    import bbpe_pkg::*;

    localparam int IDLE_PCT     = 38;    // chance of an idle cycle, per side
    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 8;     // pipeline settle time before a register write
    localparam int TAIL_CYCLES  = 16;    // quiet time after the last point
    localparam int STALL_LIMIT  = 1000;  // cycles with no transfer before giving up

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    bit                   quiet_mode;      // no idling on either side
    bit                   stream_aligned;  // block sits at the start of a frame
    int                   pixels_sent;
    int                   frames_sent;
    int                   cfg_writes;
    int                   stall_cycles;
    int                   fail_count;
    int                   pending;
    int                   points;

    bbpe_pix_if pix_if ();
    bbpe_pt_if  pt_if ();

    binary_boundary_pixel_extract_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_if    (pix_if),
        .o_pt_if     (pt_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bbpe_point_checker point_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_if),
        .i_pt         (pt_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_points     (points)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Point sink: ready drops at random unless a quiet stretch is running.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.ready <= 1'b0;
        end else begin
            pt_if.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: any transfer or register write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (pt_if.valid && pt_if.ready) ||
            cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly clean black/white content, with a small share of grey pixels that are
    // neither class; white_pct steers how dense the white regions are.
    function automatic logic [PIX_W-1:0] random_pixel(input int white_pct);
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return PIX_W'($urandom_range(1, 254));
        end
        if (r < 8 + white_pct) begin
            return PIX_WHITE;
        end
        return PIX_BLACK;
    endfunction

    // One pixel transfer. Random idle cycles go in front; valid stays high
    // between back-to-back pixels so it never toggles within one step.
    task automatic push_pixel(input logic [PIX_W-1:0] pv, input logic fs);
        if (!quiet_mode) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                pix_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= pv;
        pix_if.frame_start <= fs;
        @(posedge i_clk);
        while (!pix_if.ready) begin
            @(posedge i_clk);
        end
        pixels_sent++;
    endtask

    // Stop sending and wait for every predicted point to arrive, then give
    // the front pipeline time to flush pixels that make no point.
    task automatic drain_points();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    // Dropping the enable and waiting again after each write keeps it from toggling in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic set_config(input int raw_w, input int raw_h, input int lim);
        drain_points();
        write_reg(REG_WIDTH, raw_w);
        write_reg(REG_HEIGHT, raw_h);
        write_reg(REG_LIMIT, lim);
    endtask

    // A 3x3 directed frame, first pixel in the top byte.
    task automatic send_block(input logic [71:0] blk, input logic first_fs);
        for (int i = 0; i < 9; i++) begin
            push_pixel(blk[71 - 8 * i -: 8], (i == 0) ? first_fs : 1'b0);
        end
    endtask

    // A run of random pixels. With noise on, a stray frame start now and
    // then restarts the frame in the middle.
    task automatic send_run(input int count, input int white_pct, input logic first_fs,
                            input bit noisy);
        logic fs;
        for (int n = 0; n < count; n++) begin
            fs = (n == 0) ? first_fs : (noisy && $urandom_range(999) < 5);
            if (n != 0 && fs) begin
                stream_aligned = 1'b0;
            end
            push_pixel(random_pixel(white_pct), fs);
        end
    endtask

    // One setting, several frames. The first frame always carries a frame
    // start, so a wider line never reads store entries from before the write.
    // Later frames may rely on the implicit wrap at frame end; some get cut.
    task automatic run_phase(input int raw_w, input int raw_h, input int lim,
                             input int eff_w, input int eff_h, input int frames,
                             input int white_pct);
        int   n;
        logic fs;
        set_config(raw_w, raw_h, lim);
        stream_aligned = 1'b0;
        repeat (frames) begin
            fs = !stream_aligned || ($urandom_range(99) < 70);
            stream_aligned = 1'b1;
            if ($urandom_range(99) < 10) begin
                n = $urandom_range(1, eff_w * eff_h - 1);
                stream_aligned = 1'b0;
            end else begin
                n = eff_w * eff_h;
            end
            send_run(n, white_pct, fs, 1'b1);
            frames_sent++;
        end
    endtask

    initial begin
        int rw;
        int rh;
        int rl;

        pix_if.valid       <= 1'b0;
        pix_if.pixel_value <= PIX_BLACK;
        pix_if.frame_start <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_WIDTH;
        cfg_data           <= '0;
        i_rst_n            <= 1'b0;
        quiet_mode          = 1'b0;
        stream_aligned      = 1'b0;
        pixels_sent         = 0;
        frames_sent         = 0;
        cfg_writes          = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed 3x3 frames; the point limit stays at its reset value.
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        // frame start, black corner neighbor -> point at (1,1), index 0
        send_block(72'h00FFFF_FFFFFF_FFFFFF, 1'b1);
        // implicit start after frame end; grey neighbors are not black
        send_block(72'hFF80FF_01FFFE_FFFFFF, 1'b0);
        // partial frame, then a frame start restarts it
        push_pixel(PIX_WHITE, 1'b0);
        push_pixel(PIX_BLACK, 1'b0);
        push_pixel(8'd254, 1'b0);
        push_pixel(PIX_WHITE, 1'b0);
        send_block(72'hFFFFFF_FFFFFF_FFFF00, 1'b1);

        // small frames, top limit
        run_phase(5, 4, 16'hFFFF, 5, 4, 8, 60);
        // sizes below the minimum clamp up; zero limit means no points
        run_phase(0, 1, 0, 3, 3, 6, 60);
        // stray upper data bits are dropped; tight limit cuts points off
        run_phase(16'hF008, 16'hB006, 3, 8, 6, 5, 70);
        run_phase(2, 2, 1000, 3, 3, 6, 55);

        // long stretch with no idling on either side
        quiet_mode = 1'b1;
        run_phase(7, 7, 1000, 7, 7, 5, 65);
        quiet_mode = 1'b0;

        // Resize in the middle of a frame: shrink height while past the new
        // last row, then shrink width while past the new last column. Both
        // counters wrap at their next advance.
        set_config(12, 10, 1000);
        send_run(60, 60, 1'b1, 1'b0);
        drain_points();
        write_reg(REG_HEIGHT, 3);
        send_run(31, 60, 1'b0, 1'b0);
        drain_points();
        write_reg(REG_WIDTH, 4);
        send_run(40, 60, 1'b0, 1'b0);

        // largest raw sizes clamp to the maximum; a short stretch of each
        set_config(4095, 3, 16'hFFFF);
        send_run(60, 60, 1'b1, 1'b0);
        set_config(3, 4095, 500);
        send_run(60, 60, 1'b1, 1'b0);

        // random small settings
        repeat (2) begin
            rw = $urandom_range(MIN_SIZE, 12);
            rh = $urandom_range(MIN_SIZE, 8);
            rl = ($urandom_range(3) == 0) ? $urandom_range(0, 4) : 1000;
            run_phase(rw, rh, rl, rw, rh, $urandom_range(2, 4), $urandom_range(40, 85));
        end

        drain_points();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixels, %0d frames, %0d register writes, %0d points checked.",
                 pixels_sent, frames_sent, cfg_writes, points);
        $display("Covered directed windows, clamped and extreme sizes, limit cut-off, "
                 , "mid-frame resize and frame restarts.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
